FILE: design/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg
// Types, constants and byte classification helpers for the UTF-8 stream
// decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

   localparam int ByteW     = 8;
   localparam int CpW       = 21;
   localparam int MaxRes    = 4;
   localparam int PendDepth = 3;

   localparam logic [CpW-1:0] ReplChar = CpW'(63);

   typedef struct packed {
      logic [CpW-1:0] cp;
      logic           repl;
   } result_type;

   // Sequence length from the lead byte; zero for a byte that cannot lead.
   function automatic logic [2:0] lead_len(input logic [ByteW-1:0] b);
      logic [2:0] len;
      if (b < 8'h80) begin
         len = 3'd1;
      end else if ((b & 8'hE0) == 8'hC0) begin
         len = 3'd2;
      end else if ((b & 8'hF0) == 8'hE0) begin
         len = 3'd3;
      end else if ((b & 8'hF8) == 8'hF0) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

   function automatic logic is_cont(input logic [ByteW-1:0] b);
      return (b & 8'hC0) == 8'h80;
   endfunction

   // Assembles the code point of a complete multi-byte sequence.
   function automatic logic [CpW-1:0] seq_value(input logic [31:0] w,
                                                input logic [2:0]  len);
      logic [CpW-1:0] v;
      unique case (len)
         3'd2:    v = {10'd0, w[4:0], w[13:8]};
         3'd3:    v = {5'd0, w[3:0], w[13:8], w[21:16]};
         default: v = {w[2:0], w[13:8], w[21:16], w[29:24]};
      endcase
      return v;
   endfunction

endpackage

FILE: design/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Streaming UTF-8 decoder: one text byte per input word, decoded code points
// or replacement marks per output word.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake             Payload
// req      in   req_tvalid/tready     tdata[7:0] byte, tlast final byte
// rsp      out  rsp_tvalid/tready     tdata[20:0] code point, tuser, tlast
//
// A byte is taken every cycle while the result queue is empty or drains its
// last entry in the same cycle. A byte that yields k results (k up to four)
// holds the input while the four-entry result queue drains one word per cycle
// whenever rsp_tready is high. Reset clears the pending count and the queue;
// the pending byte store needs no clearing. A stalled output holds its word.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top
   import usd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic [1:0]  rsp_tuser,   // [0] replaced, [1] run_last
   output logic        rsp_tlast    // text_end
);

   logic [ByteW-1:0] pend_ff [0:PendDepth-1];
   logic [ByteW-1:0] pend_in [0:PendDepth-1];
   logic [1:0]       pend_cnt_ff, pend_cnt_in;
   result_type       q_ff [0:MaxRes-1];
   result_type       q_in [0:MaxRes-1];
   logic [2:0]       rem_ff, rem_in;
   logic             fin_ff, fin_in;

   logic             acc, pop;
   logic [31:0]      wv;
   logic [2:0]       wcnt;
   logic [2:0]       nres;
   logic             halt;
   logic [2:0]       len;
   logic             good;
   result_type       res [0:MaxRes-1];

   assign acc = req_tvalid && req_tready;
   assign pop = rsp_tvalid && rsp_tready;

   assign req_tready = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_tready);
   assign rsp_tvalid = rem_ff != 3'd0;
   assign rsp_tdata  = {3'd0, q_ff[0].cp};
   assign rsp_tuser  = {rem_ff == 3'd1, q_ff[0].repl};
   assign rsp_tlast  = (rem_ff == 3'd1) && fin_ff;

   always_comb begin
      wv = {req_tdata, pend_ff[2], pend_ff[1], pend_ff[0]};
      wv[8*pend_cnt_ff +: 8] = req_tdata;
      wcnt = {1'b0, pend_cnt_ff} + 3'd1;
      nres = 3'd0;
      halt = 1'b0;
      len  = 3'd0;
      good = 1'b0;
      for (int i = 0; i < MaxRes; i++) begin
         res[i] = '0;
      end
      for (int i = 0; i < MaxRes; i++) begin
         if (!halt && (wcnt != 3'd0)) begin
            len  = lead_len(wv[7:0]);
            good = 1'b1;
            if ((len >= 3'd2) && !is_cont(wv[15:8])) begin
               good = 1'b0;
            end
            if ((len >= 3'd3) && !is_cont(wv[23:16])) begin
               good = 1'b0;
            end
            if ((len == 3'd4) && !is_cont(wv[31:24])) begin
               good = 1'b0;
            end
            if (len == 3'd1) begin
               res[i] = '{cp: {13'd0, wv[7:0]}, repl: 1'b0};
               nres   = nres + 3'd1;
               wv     = wv >> 8;
               wcnt   = wcnt - 3'd1;
            end else if (len == 3'd0) begin
               res[i] = '{cp: ReplChar, repl: 1'b1};
               nres   = nres + 3'd1;
               wv     = wv >> 8;
               wcnt   = wcnt - 3'd1;
            end else if (wcnt < len) begin
               if (!req_tlast) begin
                  halt = 1'b1;
               end else begin
                  res[i] = '{cp: ReplChar, repl: 1'b1};
                  nres   = nres + 3'd1;
                  wcnt   = 3'd0;
               end
            end else if (good) begin
               res[i] = '{cp: seq_value(wv, len), repl: 1'b0};
               nres   = nres + 3'd1;
               wv     = wv >> (8 * len);
               wcnt   = wcnt - len;
            end else begin
               res[i] = '{cp: ReplChar, repl: 1'b1};
               nres   = nres + 3'd1;
               wv     = wv >> 8;
               wcnt   = wcnt - 3'd1;
            end
         end
      end
      if (req_tlast) begin
         wcnt = 3'd0;
      end
   end

   always_comb begin
      pend_in     = pend_ff;
      pend_cnt_in = pend_cnt_ff;
      q_in        = q_ff;
      rem_in      = rem_ff;
      fin_in      = fin_ff;
      if (acc) begin
         pend_in[0]  = wv[7:0];
         pend_in[1]  = wv[15:8];
         pend_in[2]  = wv[23:16];
         pend_cnt_in = wcnt[1:0];
         q_in        = res;
         rem_in      = nres;
         fin_in      = req_tlast;
      end else if (pop) begin
         for (int i = 0; i < MaxRes - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
         rem_in = rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= '0;
         rem_ff      <= '0;
      end else begin
         pend_cnt_ff <= pend_cnt_in;
         rem_ff      <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      q_ff    <= q_in;
      fin_ff  <= fin_in;
   end

   a_accept_when_drained: assert property (@(posedge clock) disable iff (reset)
      acc |-> ((rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_tready)))
      else $error("byte accepted while results still queued");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 3'd4)
      else $error("result queue count out of range");

   a_final_flushes: assert property (@(posedge clock) disable iff (reset)
      (acc && req_tlast) |=> (pend_cnt_ff == 2'd0))
      else $error("pending bytes left after final byte");

   a_final_yields: assert property (@(posedge clock) disable iff (reset)
      (acc && req_tlast) |=> (rem_ff != 3'd0))
      else $error("final byte produced no result");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[1])
      else $error("text end flagged on a word that is not last of its run");

endmodule
